/* design/lmhfs_pkg.sv */
package lmhfs_pkg;

	localparam int FRAME_PIXELS_DEF = 524288;
	localparam int QUEUE_DEPTH      = 4;
	localparam int CFG_IW           = 2;

	localparam logic [CFG_IW-1:0] REG_COLOR_MODE = 2'd0;
	localparam logic [CFG_IW-1:0] REG_HOLD       = 2'd1;

	// one pixel operation as it travels from front to back
	typedef struct packed {
		logic [7:0] y;
		logic [7:0] u;
		logic [7:0] v;
		logic       fresh;
		logic       color;
		logic       last;
	} pix_word_t;

endpackage

/* design/lmhfs_front.sv */
module lmhfs_front import lmhfs_pkg::*; #(
	parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
	localparam int AW = $clog2(FRAME_PIXELS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic              cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [7:0]        pix_y,
	input  logic [7:0]        pix_u,
	input  logic [7:0]        pix_v,
	input  logic              frame_end,
	output logic              push_en,
	input  logic              push_ready,
	output logic [AW-1:0]     push_addr,
	output pix_word_t         push_word
);

	logic          color_mode_q;
	logic          hold_q;
	logic          fresh_q;
	logic [AW-1:0] addr_q;
	logic          accept;
	logic          wrap;

	assign cfg_ready = 1'b1;
	assign in_ready  = push_ready;
	assign accept    = in_valid && in_ready;
	assign push_en   = accept && !mode && !hold_q;
	assign wrap      = frame_end || (addr_q == AW'(FRAME_PIXELS - 1));

	assign push_addr       = addr_q;
	assign push_word.y     = pix_y;
	assign push_word.u     = pix_u;
	assign push_word.v     = pix_v;
	assign push_word.fresh = fresh_q;
	assign push_word.color = color_mode_q;
	assign push_word.last  = frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b0;
			hold_q       <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COLOR_MODE: color_mode_q <= cfg_data;
				REG_HOLD:       hold_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
			addr_q  <= '0;
		end else if (accept && mode) begin
			fresh_q <= 1'b1;
			addr_q  <= '0;
		end else if (push_en) begin
			if (wrap) begin
				fresh_q <= 1'b0;
				addr_q  <= '0;
			end else begin
				addr_q <= addr_q + AW'(1);
			end
		end
	end

endmodule

/* design/lmhfs_queue.sv */
module lmhfs_queue import lmhfs_pkg::*; #(
	parameter int AW = 19,
	localparam int QAW = $clog2(QUEUE_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_en,
	output logic          push_ready,
	input  logic [AW-1:0] push_addr,
	input  pix_word_t     push_word,
	output logic          q_valid,
	input  logic          pop_en,
	output logic [AW-1:0] q_addr,
	output pix_word_t     q_word
);

	logic [AW-1:0] addr_mem [QUEUE_DEPTH];
	pix_word_t     word_mem [QUEUE_DEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   count_q;

	assign push_ready = (count_q != (QAW+1)'(QUEUE_DEPTH));
	assign q_valid    = (count_q != '0);
	assign q_addr     = addr_mem[rd_q];
	assign q_word     = word_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push_en) begin
			addr_mem[wr_q] <= push_addr;
			word_mem[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push_en)
				wr_q <= wr_q + QAW'(1);
			if (pop_en)
				rd_q <= rd_q + QAW'(1);
			case ({push_en, pop_en})
				2'b10:   count_q <= count_q + (QAW+1)'(1);
				2'b01:   count_q <= count_q - (QAW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/lmhfs_back.sv */
module lmhfs_back import lmhfs_pkg::*; #(
	parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
	localparam int AW = $clog2(FRAME_PIXELS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          pop_en,
	input  logic [AW-1:0] q_addr,
	input  pix_word_t     q_word,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    held_y,
	output logic [7:0]    held_u,
	output logic [7:0]    held_v,
	output logic          frame_done
);

	logic [23:0]   store [FRAME_PIXELS];
	logic [23:0]   rdata_q;
	logic          fwd_q;
	logic [23:0]   fwd_data_q;
	logic          s1_valid_q;
	logic [AW-1:0] s1_addr_q;
	pix_word_t     s1_word_q;
	logic          out_valid_q;
	logic          s1_adv;
	logic [23:0]   base;
	logic [23:0]   next_pix;

	assign s1_adv = s1_valid_q && (!out_valid_q || out_ready);
	assign pop_en = q_valid && (!s1_valid_q || s1_adv);

	// word just written by s1 is not yet visible to a read on the same edge
	always_comb begin
		if (s1_word_q.fresh)
			base = '0;
		else if (fwd_q)
			base = fwd_data_q;
		else
			base = rdata_q;
		next_pix = base;
		if (s1_word_q.y > base[23:16]) begin
			next_pix[23:16] = s1_word_q.y;
			if (s1_word_q.color)
				next_pix[15:0] = {s1_word_q.u, s1_word_q.v};
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			store[s1_addr_q] <= next_pix;
		if (pop_en)
			rdata_q <= store[q_addr];
	end

	always_ff @(posedge clk) begin
		if (pop_en) begin
			s1_addr_q  <= q_addr;
			s1_word_q  <= q_word;
			fwd_data_q <= next_pix;
		end
		if (s1_adv) begin
			held_y     <= next_pix[23:16];
			held_u     <= next_pix[15:8];
			held_v     <= next_pix[7:0];
			frame_done <= s1_word_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			fwd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_en) begin
				s1_valid_q <= 1'b1;
				fwd_q      <= s1_adv && (s1_addr_q == q_addr);
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
				fwd_q      <= 1'b0;
			end
			if (s1_adv)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_fwd_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> s1_valid_q)
		else $error("forward flag set with empty s1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !out_ready) |=> (s1_valid_q && $stable(s1_addr_q)))
		else $error("s1 moved while output stalled");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop_en |=> s1_valid_q)
		else $error("popped word lost");

	a_adv_shows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid_q)
		else $error("result not presented");

endmodule

/* design/luma_max_hold_frame_stacker_core.sv */
// Max-hold frame stacker: pixels stream in raster order with an internal address counter,
// each one a read-modify-write of a 24-bit Y/U/V frame store of FRAME_PIXELS words. A front
// stage handles clear/hold and the counter, a 4-word queue decouples it from the back stage,
// which reads the store, keeps the larger luma (and its chroma in color mode) and writes back.
// Throughput is one pixel per clock while out_ready holds, set by the single read and single
// write port of the store; a result passes the queue, s1 and the output register. Clear and
// held pixels produce no result. The store has no reset: after reset or clear the first frame
// compares against zero, and each frame must cover every address before a later one reads it.
module luma_max_hold_frame_stacker_core import lmhfs_pkg::*; #(
	parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic              cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [7:0]        pix_y,
	input  logic [7:0]        pix_u,
	input  logic [7:0]        pix_v,
	input  logic              frame_end,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        held_y,
	output logic [7:0]        held_u,
	output logic [7:0]        held_v,
	output logic              frame_done
);

	localparam int AW = $clog2(FRAME_PIXELS);

	logic          push_en;
	logic          push_ready;
	logic [AW-1:0] push_addr;
	pix_word_t     push_word;
	logic          q_valid;
	logic          pop_en;
	logic [AW-1:0] q_addr;
	pix_word_t     q_word;

	lmhfs_front #(.FRAME_PIXELS(FRAME_PIXELS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.pix_y      (pix_y),
		.pix_u      (pix_u),
		.pix_v      (pix_v),
		.frame_end  (frame_end),
		.push_en    (push_en),
		.push_ready (push_ready),
		.push_addr  (push_addr),
		.push_word  (push_word)
	);

	lmhfs_queue #(.AW(AW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_en    (push_en),
		.push_ready (push_ready),
		.push_addr  (push_addr),
		.push_word  (push_word),
		.q_valid    (q_valid),
		.pop_en     (pop_en),
		.q_addr     (q_addr),
		.q_word     (q_word)
	);

	lmhfs_back #(.FRAME_PIXELS(FRAME_PIXELS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.pop_en     (pop_en),
		.q_addr     (q_addr),
		.q_word     (q_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.held_y     (held_y),
		.held_u     (held_u),
		.held_v     (held_v),
		.frame_done (frame_done)
	);

endmodule
